@@ rtl/smpf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smpf_pkg
// Shared types and constants of the selective median pixel filter.
// ----------------------------------------------------------------------------
package smpf_pkg;

  localparam int unsigned BINS = 256;

  localparam logic [1:0] REG_RADIUS    = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_WIDTH     = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic start_item;   // latch item, write line store
    logic clr_hist;     // clear one bin (addressed by scan counter)
    logic load_win;     // read one window tap into histograms
    logic scan;         // median search step over bins
    logic choose;       // form result from medians
    logic advance;      // move to next column of run
    logic finish;       // update position counters
  } smpf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic has_run;      // item releases results
    logic clr_done;
    logic win_done;
    logic scan_done;
    logic run_last;     // current column is last of run
  } smpf_sts_t;

endpackage

`default_nettype wire

@@ rtl/smpf_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smpf_ctrl
// Sequencer: item intake, histogram clear, window fill, median scan, output.
// ----------------------------------------------------------------------------
module smpf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output smpf_pkg::smpf_cmd_t    cmd,
  input  wire smpf_pkg::smpf_sts_t sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_CLR  = 3'd2;
  localparam logic [2:0] S_WIN  = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_SEL  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start_item = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.has_run) state_nxt = S_CLR;
        else begin
          cmd.finish = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_CLR: begin
        cmd.clr_hist = 1'b1;
        if (sts.clr_done) state_nxt = S_WIN;
      end
      S_WIN: begin
        cmd.load_win = 1'b1;
        if (sts.win_done) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = S_SEL;
      end
      S_SEL: begin
        cmd.choose = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.run_last) begin
            cmd.finish = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_nxt = S_CLR;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/smpf_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smpf_dp
// Datapath: line store, window readout, three histograms and median scan.
// ----------------------------------------------------------------------------
module smpf_dp #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_RADIUS = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire smpf_pkg::smpf_cmd_t cmd,
  output smpf_pkg::smpf_sts_t     sts,
  input  wire logic [2:0]         radius_reg,
  input  wire logic [7:0]         thr_reg,
  input  wire logic [10:0]        width_reg,
  input  wire logic               in_func,
  input  wire logic               in_frame_start,
  input  wire logic [7:0]         in_red,
  input  wire logic [7:0]         in_green,
  input  wire logic [7:0]         in_blue,
  output logic [7:0]              out_red,
  output logic [7:0]              out_green,
  output logic [7:0]              out_blue,
  output logic                    out_last_of_run
);

  localparam int unsigned ROWS = 2 * MAX_RADIUS + 1;
  localparam int unsigned RW   = $clog2(ROWS);
  localparam int unsigned XW   = $clog2(MAX_WIDTH);
  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned AW   = $clog2(ROWS * MAX_WIDTH);
  localparam int unsigned PW   = $clog2(2 * MAX_RADIUS + 1);
  localparam int unsigned KW   = $clog2(2 * MAX_RADIUS + 2);
  localparam int unsigned HW   = $clog2(ROWS * ROWS + 1);

  // effective configuration
  logic [PW-1:0] rad;
  logic [WW-1:0] wid;
  always_comb begin
    if (radius_reg == 3'd0) rad = PW'(1);
    else if (32'(radius_reg) > MAX_RADIUS) rad = PW'(MAX_RADIUS);
    else rad = PW'(radius_reg);
    if (width_reg == 11'd0) wid = WW'(1);
    else if (32'(width_reg) > MAX_WIDTH) wid = WW'(MAX_WIDTH);
    else wid = WW'(width_reg);
  end

  logic [PW-1:0] rowp_r;
  logic [WW-1:0] colp_r;
  logic [RW-1:0] head_r;
  logic [XW-1:0] x_r;
  logic [RW-1:0] xhead_r;
  logic [PW-1:0] xrowp_r;

  // memory
  logic [23:0] mem [ROWS*MAX_WIDTH];
  logic [23:0] rdata_r;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [23:0]   wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  function automatic logic [RW-1:0] slot_up(input logic [RW-1:0] h,
                                            input logic [PW-1:0] d);
    logic [RW:0] t;
    t = {1'b0, h} + (RW+1)'(ROWS) - (RW+1)'(d);
    if (t >= (RW+1)'(ROWS)) t = t - (RW+1)'(ROWS);
    return t[RW-1:0];
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] s,
                                            input logic [XW-1:0] c);
    return AW'(s) * AW'(MAX_WIDTH) + AW'(c);
  endfunction

  // intake: two phases. Phase 0 (start cycle) decides position and reads the
  // drain source; write happens in DEC cycle.
  logic          func_r;
  logic [23:0]   pix_r;
  logic          dec_r;
  logic [PW-1:0] rowp_eff;
  logic [RW-1:0] head_eff;
  logic [WW-1:0] col_eff;
  always_comb begin
    rowp_eff = rowp_r; head_eff = head_r; col_eff = colp_r;
    if (in_frame_start) begin
      rowp_eff = '0; head_eff = '0; col_eff = '0;
    end else if (colp_r >= wid) begin
      col_eff = '0;
      if (32'(rowp_r) < 2 * MAX_RADIUS) rowp_eff = rowp_r + PW'(1);
      head_eff = (32'(head_r) == ROWS - 1) ? '0 : head_r + RW'(1);
    end
  end

  // run bookkeeping
  logic [XW-1:0] c_r, last_r;
  logic          have;
  logic [XW:0]   xr;
  logic [PW-1:0] dd_r;   // row offset counter
  logic [KW-1:0] k_r;    // column offset counter
  logic [8:0]    bin_r;
  logic          pend_r; // read issued last cycle
  logic          fin_r;  // final read issued
  logic [HW-1:0] hr [smpf_pkg::BINS];
  logic [HW-1:0] hg [smpf_pkg::BINS];
  logic [HW-1:0] hb [smpf_pkg::BINS];
  logic [HW-1:0] ar_r, ag_r, ab_r;
  logic [7:0]    mr_r, mg_r, mb_r;
  logic          fr_r, fg_r, fb_r;
  logic [23:0]   cen_r;
  logic [HW-1:0] half;
  logic [PW:0]   side;
  logic [HW-1:0] hrd_r, hgd_r, hbd_r;  // bin counts read for increment
  logic [23:0]   key_r;                // tap whose bins are incremented
  logic          inc_r;                // increment write pending
  logic [HW-1:0] hqr_r, hqg_r, hqb_r;  // bin counts read for median search
  logic [7:0]    qbin_r;
  logic          qv_r;
  logic          tap_in;               // rdata_r holds a window tap

  assign side = {rad, 1'b1};
  assign half = HW'((32'(side) * 32'(side)) >> 1);
  assign tap_in = cmd.load_win && pend_r && !(fin_r && k_r == KW'(1));

  // window tap address
  logic [PW-1:0] ddc;
  logic signed [XW+2:0] colc;
  logic [XW-1:0] colx;
  always_comb begin
    ddc = (dd_r > xrowp_r) ? xrowp_r : dd_r;
    colc = $signed({3'b000, c_r}) + $signed((XW+3)'(k_r)) - $signed((XW+3)'(rad));
    if (colc < 0) colx = '0;
    else if (colc > $signed((XW+3)'(wid) - (XW+3)'(1))) colx = XW'(wid - WW'(1));
    else colx = colc[XW-1:0];
  end

  always_comb begin
    raddr = addr_of(slot_up(head_eff, PW'(1)), XW'(col_eff));
    if (cmd.load_win) raddr = fin_r ? addr_of(slot_up(xhead_r, rad), c_r)
                                    : addr_of(slot_up(xhead_r, ddc), colx);
    we = dec_r;
    waddr = addr_of(xhead_r, x_r);
    wdata = func_r ? ((xrowp_r != '0) ? rdata_r : 24'd0) : pix_r;
  end

  assign xr = {1'b0, x_r};
  always_comb begin
    have = 1'b0;
    if (xrowp_r >= rad) begin
      if (WW'(x_r) == wid - WW'(1)) have = 1'b1;
      else if (xr >= (XW+1)'(rad)) have = 1'b1;
    end
  end

  assign sts.has_run   = have;
  assign sts.clr_done  = (bin_r == 9'd255);
  assign sts.win_done  = pend_r && fin_r && (k_r == KW'(1));
  assign sts.scan_done = (qv_r && qbin_r == 8'd255) || (fr_r && fg_r && fb_r);
  assign sts.run_last  = (c_r == last_r);

  function automatic logic [7:0] pick(input logic [7:0] s, input logic [7:0] m,
                                      input logic [7:0] t);
    logic [7:0] d;
    d = (s > m) ? s - m : m - s;
    return (d > t) ? m : s;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rowp_r <= '0; colp_r <= '0; head_r <= '0; dec_r <= 1'b0;
      bin_r <= '0; pend_r <= 1'b0; fin_r <= 1'b0;
      inc_r <= 1'b0; qv_r <= 1'b0;
    end else begin
      dec_r <= cmd.start_item;
      if (cmd.start_item) begin
        func_r  <= in_func;
        pix_r   <= {in_red, in_green, in_blue};
        x_r     <= XW'(col_eff);
        xhead_r <= head_eff;
        xrowp_r <= rowp_eff;
        rowp_r  <= rowp_eff;
        head_r  <= head_eff;
      end
      if (dec_r) begin
        last_r <= (WW'(x_r) == wid - WW'(1)) ? XW'(wid - WW'(1)) : XW'(x_r - XW'(rad));
        c_r    <= (xr >= (XW+1)'(rad)) ? XW'(x_r - XW'(rad)) : '0;
      end
      if (cmd.clr_hist) begin
        hr[bin_r[7:0]] <= '0; hg[bin_r[7:0]] <= '0; hb[bin_r[7:0]] <= '0;
        bin_r <= (bin_r == 9'd255) ? 9'd0 : bin_r + 9'd1;
        dd_r <= '0; k_r <= '0; pend_r <= 1'b0; fin_r <= 1'b0;
        ar_r <= '0; ag_r <= '0; ab_r <= '0;
        fr_r <= 1'b0; fg_r <= 1'b0; fb_r <= 1'b0;
        qv_r <= 1'b0;
      end
      // bin increment: registered read, write in the following cycle
      inc_r <= tap_in;
      if (tap_in) begin
        key_r <= rdata_r;
        // same bin as the write in progress: take the value being written
        hrd_r <= (inc_r && key_r[23:16] == rdata_r[23:16]) ? hrd_r + HW'(1)
                                                          : hr[rdata_r[23:16]];
        hgd_r <= (inc_r && key_r[15:8] == rdata_r[15:8]) ? hgd_r + HW'(1)
                                                        : hg[rdata_r[15:8]];
        hbd_r <= (inc_r && key_r[7:0] == rdata_r[7:0]) ? hbd_r + HW'(1)
                                                      : hb[rdata_r[7:0]];
      end
      if (inc_r) begin
        hr[key_r[23:16]] <= hrd_r + HW'(1);
        hg[key_r[15:8]]  <= hgd_r + HW'(1);
        hb[key_r[7:0]]   <= hbd_r + HW'(1);
      end
      if (cmd.load_win) begin
        if (pend_r && fin_r) begin
          k_r <= KW'(1);
          if (k_r == KW'(1)) cen_r <= rdata_r;
        end else if (!fin_r) begin
          pend_r <= 1'b1;
          if (KW'(k_r) == KW'(side - 1)) begin
            k_r <= '0;
            if (dd_r == PW'(side - 1)) fin_r <= 1'b1;
            else dd_r <= dd_r + PW'(1);
          end else k_r <= k_r + KW'(1);
        end else begin
          pend_r <= 1'b1; k_r <= '0;
        end
      end
      if (cmd.scan) begin
        // bin read issued now, accumulated next cycle
        hqr_r  <= hr[bin_r[7:0]];
        hqg_r  <= hg[bin_r[7:0]];
        hqb_r  <= hb[bin_r[7:0]];
        qbin_r <= bin_r[7:0];
        qv_r   <= !bin_r[8] && !sts.scan_done;
        if (qv_r && !fr_r) begin
          ar_r <= ar_r + hqr_r;
          if (ar_r + hqr_r > half) begin fr_r <= 1'b1; mr_r <= qbin_r; end
        end
        if (qv_r && !fg_r) begin
          ag_r <= ag_r + hqg_r;
          if (ag_r + hqg_r > half) begin fg_r <= 1'b1; mg_r <= qbin_r; end
        end
        if (qv_r && !fb_r) begin
          ab_r <= ab_r + hqb_r;
          if (ab_r + hqb_r > half) begin fb_r <= 1'b1; mb_r <= qbin_r; end
        end
        if (sts.scan_done) bin_r <= '0;
        else if (!bin_r[8]) bin_r <= bin_r + 9'd1;
      end
      if (cmd.choose) begin
        out_red   <= pick(cen_r[23:16], fr_r ? mr_r : 8'd255, thr_reg);
        out_green <= pick(cen_r[15:8],  fg_r ? mg_r : 8'd255, thr_reg);
        out_blue  <= pick(cen_r[7:0],   fb_r ? mb_r : 8'd255, thr_reg);
        out_last_of_run <= (c_r == last_r);
      end
      if (cmd.advance) c_r <= c_r + XW'(1);
      if (cmd.finish) begin
        colp_r <= WW'(x_r) + WW'(1);
        if (WW'(x_r) + WW'(1) >= wid) begin
          colp_r <= '0;
          if (32'(rowp_r) < 2 * MAX_RADIUS) rowp_r <= rowp_r + PW'(1);
          head_r <= (32'(head_r) == ROWS - 1) ? '0 : head_r + RW'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/selective_median_pixel_filter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Synchronous active-low reset clears positions and control; registers return to 3, 40, 1024.
// ----------------------------------------------------------------------------
// selective_median_pixel_filter
// Switching median filter over a square RGB window with line storage.
// ----------------------------------------------------------------------------
module selective_median_pixel_filter #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_RADIUS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_func,
  input  wire logic        in_frame_start,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic             out_last_of_run,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [2:0]  radius_r;
  logic [7:0]  thr_r;
  logic [10:0] width_r;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 3'd3; thr_r <= 8'd40; width_r <= 11'd1024;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[3:2] == smpf_pkg::REG_RADIUS)    radius_r <= cfg_pwdata[2:0];
      if (cfg_paddr[3:2] == smpf_pkg::REG_THRESHOLD) thr_r    <= cfg_pwdata[7:0];
      if (cfg_paddr[3:2] == smpf_pkg::REG_WIDTH)     width_r  <= cfg_pwdata[10:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[1:0] == 2'b00) begin
      unique case (cfg_paddr[3:2])
        smpf_pkg::REG_RADIUS:    cfg_prdata = {29'd0, radius_r};
        smpf_pkg::REG_THRESHOLD: cfg_prdata = {24'd0, thr_r};
        smpf_pkg::REG_WIDTH:     cfg_prdata = {21'd0, width_r};
        default:                 cfg_prdata = '0;
      endcase
    end
  end

  smpf_pkg::smpf_cmd_t cmd;
  smpf_pkg::smpf_sts_t sts;

  smpf_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .sts
  );

  smpf_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .radius_reg(radius_r), .thr_reg(thr_r), .width_reg(width_r),
    .in_func, .in_frame_start, .in_red, .in_green, .in_blue,
    .out_red, .out_green, .out_blue, .out_last_of_run
  );

endmodule

`default_nettype wire
